// ----- rtl/idst_pkg.sv -----
`default_nettype none

package idst_pkg;

	localparam int KEY_FIELD_W  = 32;
	localparam int DATA_FIELD_W = 32;
	localparam int SLOT_FIELD_W = 4;

	typedef enum logic [1:0] {
		FUNC_ALLOC = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_FREE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_PRESENT = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		func_t                   func;
		logic [KEY_FIELD_W-1:0]  key;
		logic [DATA_FIELD_W-1:0] wdata;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic [DATA_FIELD_W-1:0] rdata;
		logic [SLOT_FIELD_W-1:0] slot;
	} rsp_t;

endpackage

`default_nettype wire

// ----- rtl/id_keyed_slot_table.sv -----
// Items are taken one at a time: the next item is accepted only once the
// result of the last is loaded, after the slot-by-slot scan of the key memory
// through its single read port (one slot per cycle).
// A new item is taken while the previous result still waits at the output.
// Reset: asynchronous, active low; all slots become free at once.
`default_nettype none

module id_keyed_slot_table
	import idst_pkg::*;
#(
	parameter int SLOTS      = 16,
	parameter int KEY_WIDTH  = 32,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_ACT,
		S_RESP
	} state_t;

	state_t                state_q;
	req_t                  item_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  rd_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic                  hole_q;
	logic [IDX_W-1:0]      hole_idx_q;
	status_t               status_q;
	logic [IDX_W-1:0]      slot_q;
	logic                  rd_sel_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic [KEY_WIDTH+KEY_FIELD_W-1:0]   key_ext;
	logic [DATA_WIDTH+DATA_FIELD_W-1:0] wdata_ext;
	logic [KEY_WIDTH-1:0]               item_key;
	logic [DATA_WIDTH-1:0]              item_wdata;
	logic                               scan_rd;
	logic [KEY_WIDTH-1:0]               rd_key;
	logic                               rd_valid;
	logic                               act;
	logic                               alloc_en;
	logic                               free_en;
	logic                               dwr_en;
	logic [IDX_W-1:0]                   dwr_addr;
	logic [DATA_WIDTH-1:0]              dwr_data;
	logic                               drd_en;
	logic [DATA_WIDTH-1:0]              drd_data;
	logic [DATA_WIDTH+DATA_FIELD_W-1:0] rdata_ext;
	logic [IDX_W+SLOT_FIELD_W-1:0]      slot_ext;
	logic                               key_match;
	logic                               rsp_load;

	assign key_ext    = {{KEY_WIDTH{1'b0}}, item_q.key};
	assign wdata_ext  = {{DATA_WIDTH{1'b0}}, item_q.wdata};
	assign item_key   = key_ext[KEY_WIDTH-1:0];
	assign item_wdata = wdata_ext[DATA_WIDTH-1:0];

	assign scan_rd   = (state_q == S_SCAN) && (cnt_q < CNT_W'(SLOTS));
	assign key_match = rd_valid && (rd_key == item_key);

	assign act      = (state_q == S_ACT);
	assign alloc_en = act && (item_q.func == FUNC_ALLOC) && !hit_q && hole_q;
	assign free_en  = act && (item_q.func == FUNC_FREE) && hit_q;
	assign dwr_en   = alloc_en || (act && (item_q.func == FUNC_WRITE) && hit_q);
	assign dwr_addr = alloc_en ? hole_idx_q : hit_idx_q;
	assign dwr_data = alloc_en ? '0 : item_wdata;
	assign drd_en   = act && (item_q.func == FUNC_READ) && hit_q;

	assign rdata_ext = {{DATA_FIELD_W{1'b0}}, (rd_sel_q ? drd_data : '0)};
	assign slot_ext  = {{SLOT_FIELD_W{1'b0}}, slot_q};
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);

	idst_key_store #(
		.SLOTS    (SLOTS),
		.KEY_WIDTH(KEY_WIDTH),
		.IDX_W    (IDX_W)
	) u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (scan_rd),
		.rd_addr   (cnt_q[IDX_W-1:0]),
		.rd_key    (rd_key),
		.rd_valid  (rd_valid),
		.alloc_en  (alloc_en),
		.alloc_addr(hole_idx_q),
		.alloc_key (item_key),
		.free_en   (free_en),
		.free_addr (hit_idx_q)
	);

	idst_data_store #(
		.SLOTS     (SLOTS),
		.DATA_WIDTH(DATA_WIDTH),
		.IDX_W     (IDX_W)
	) u_data (
		.clk    (clk),
		.rd_en  (drd_en),
		.rd_addr(hit_idx_q),
		.rd_data(drd_data),
		.wr_en  (dwr_en),
		.wr_addr(dwr_addr),
		.wr_data(dwr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			idx_s1      <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hole_q      <= 1'b0;
			hole_idx_q  <= '0;
			status_q    <= ST_DONE;
			slot_q      <= '0;
			rd_sel_q    <= 1'b0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						item_q  <= req;
						cnt_q   <= '0;
						rd_s1   <= 1'b0;
						hit_q   <= 1'b0;
						hole_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_s1  <= scan_rd;
					idx_s1 <= cnt_q[IDX_W-1:0];
					if (scan_rd) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (rd_s1) begin
						if (key_match && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_s1;
						end
						if (!rd_valid && !hole_q) begin
							hole_q     <= 1'b1;
							hole_idx_q <= idx_s1;
						end
						if (!scan_rd) begin
							state_q <= S_ACT;
						end
					end
				end
				S_ACT: begin
					rd_sel_q <= drd_en;
					priority if (item_q.func == FUNC_ALLOC) begin
						priority if (hit_q) begin
							status_q <= ST_PRESENT;
							slot_q   <= hit_idx_q;
						end else if (!hole_q) begin
							status_q <= ST_FULL;
							slot_q   <= '0;
						end else begin
							status_q <= ST_DONE;
							slot_q   <= hole_idx_q;
						end
					end else if (!hit_q) begin
						status_q <= ST_MISSING;
						slot_q   <= '0;
					end else begin
						status_q <= ST_DONE;
						slot_q   <= hit_idx_q;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						rsp_q.status <= status_q;
						rsp_q.rdata  <= rdata_ext[DATA_FIELD_W-1:0];
						rsp_q.slot   <= slot_ext[SLOT_FIELD_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/idst_key_store.sv -----
`default_nettype none

module idst_key_store #(
	parameter int SLOTS     = 16,
	parameter int KEY_WIDTH = 32,
	parameter int IDX_W     = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rd_en,
	input  wire logic [IDX_W-1:0]     rd_addr,
	output logic      [KEY_WIDTH-1:0] rd_key,
	output logic                      rd_valid,
	input  wire logic                 alloc_en,
	input  wire logic [IDX_W-1:0]     alloc_addr,
	input  wire logic [KEY_WIDTH-1:0] alloc_key,
	input  wire logic                 free_en,
	input  wire logic [IDX_W-1:0]     free_addr
);

	logic [KEY_WIDTH-1:0] key_mem [SLOTS];
	logic                 valid_q [SLOTS];
	logic [KEY_WIDTH-1:0] rd_key_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (alloc_en) begin
			key_mem[alloc_addr] <= alloc_key;
		end
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				valid_q[i] <= 1'b0;
			end
			rd_valid_q <= 1'b0;
		end else begin
			if (alloc_en) begin
				valid_q[alloc_addr] <= 1'b1;
			end
			if (free_en) begin
				valid_q[free_addr] <= 1'b0;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_key   = rd_key_q;
	assign rd_valid = rd_valid_q;

endmodule

`default_nettype wire

// ----- rtl/idst_data_store.sv -----
`default_nettype none

module idst_data_store #(
	parameter int SLOTS      = 16,
	parameter int DATA_WIDTH = 32,
	parameter int IDX_W      = 4
) (
	input  wire logic                  clk,
	input  wire logic                  rd_en,
	input  wire logic [IDX_W-1:0]      rd_addr,
	output logic      [DATA_WIDTH-1:0] rd_data,
	input  wire logic                  wr_en,
	input  wire logic [IDX_W-1:0]      wr_addr,
	input  wire logic [DATA_WIDTH-1:0] wr_data
);

	logic [DATA_WIDTH-1:0] data_mem [SLOTS];
	logic [DATA_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= data_mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/idst_checker.sv -----
`default_nettype none

module idst_checker
	import idst_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	logic [2:0] pending_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {2'b0, req_acc} - {2'b0, rsp_acc};
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed or dropped while stalled");

	a_rsp_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 3'd0)
		else $error("result without an accepted item");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("too many items outstanding");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("item taken while scan in progress");

	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_MISSING)
			|-> rsp.slot == '0 && rsp.rdata == '0)
		else $error("failed operation reports slot or data");

endmodule

bind id_keyed_slot_table idst_checker u_idst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

`default_nettype wire

// ----- dv/id_keyed_slot_table_tb.sv -----
`default_nettype none

module id_keyed_slot_table_tb;
	import idst_pkg::*;

	localparam int SLOTS        = 16;
	localparam int RANDOM_ITEMS = 900;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 40;
	localparam int POOL_SIZE    = 24;

	typedef struct {
		req_t item;
		bit   typed;
		rsp_t want;
	} step_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	req_t req       = '0;
	logic rsp_ready = 1'b0;
	logic req_ready;
	logic rsp_valid;
	rsp_t rsp;

	bit                    occupied [SLOTS];
	logic [KEY_FIELD_W-1:0]  stored_key [SLOTS];
	logic [DATA_FIELD_W-1:0] stored_data [SLOTS];

	rsp_t  pending_rsp [$];
	step_t plan [$];
	logic [KEY_FIELD_W-1:0] key_pool [POOL_SIZE];

	int mismatch_count = 0;
	int quiet_cycles   = 0;
	int rsp_hold       = 0;
	bit req_calm       = 1'b0;
	bit rsp_calm       = 1'b0;
	bit filling        = 1'b1;

	id_keyed_slot_table #(.SLOTS(SLOTS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic rsp_t apply_request(req_t r);
		rsp_t res;
		int   hit;
		int   hole;
		res  = '0;
		hit  = -1;
		hole = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (occupied[i]) begin
				if (hit < 0 && stored_key[i] == r.key)
					hit = i;
			end else if (hole < 0) begin
				hole = i;
			end
		end
		if (r.func == FUNC_ALLOC) begin
			if (hit >= 0) begin
				res.status = ST_PRESENT;
				res.slot   = hit[SLOT_FIELD_W-1:0];
			end else if (hole < 0) begin
				res.status = ST_FULL;
			end else begin
				occupied[hole]   = 1'b1;
				stored_key[hole] = r.key;
				res.slot         = hole[SLOT_FIELD_W-1:0];
			end
		end else if (hit < 0) begin
			res.status = ST_MISSING;
		end else begin
			res.slot = hit[SLOT_FIELD_W-1:0];
			case (r.func)
			FUNC_READ: begin
				res.rdata = stored_data[hit];
			end
			FUNC_WRITE: begin
				stored_data[hit] = r.wdata;
			end
			default: begin
				occupied[hit]    = 1'b0;
				stored_data[hit] = '0;
			end
			endcase
		end
		return res;
	endfunction

	function automatic int count_used();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			n += occupied[i];
		return n;
	endfunction

	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 29) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic logic [KEY_FIELD_W-1:0] pick_key(int hit_pct);
		int idx;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < hit_pct && count_used() > 0) begin
			idx = $urandom_range(0, SLOTS-1);
			while (!occupied[idx])
				idx = (idx + 1) % SLOTS;
			return stored_key[idx];
		end
		if ($urandom_range(0, 9) < 8)
			return key_pool[$urandom_range(0, POOL_SIZE-1)];
		return $urandom;
	endfunction

	function automatic logic [DATA_FIELD_W-1:0] pick_data();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		default: return $urandom;
		endcase
	endfunction

	task automatic add_step(func_t f, logic [KEY_FIELD_W-1:0] k,
			logic [DATA_FIELD_W-1:0] d, bit typed, rsp_t want);
		step_t s;
		s.item.func  = f;
		s.item.key   = k;
		s.item.wdata = d;
		s.typed      = typed;
		s.want       = want;
		plan.push_back(s);
	endtask

	task automatic push_item(req_t r, bit typed, rsp_t want);
		int   gap;
		rsp_t got;
		gap = draw_wait(req_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (!req_ready);
		got = apply_request(r);
		pending_rsp.push_back(typed ? want : got);
	endtask

	task automatic report(string field, logic [DATA_FIELD_W-1:0] exp_v,
			logic [DATA_FIELD_W-1:0] act_v);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				report("unexpected item", '0, rsp.rdata);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status != want.status)
					report("status", DATA_FIELD_W'(want.status),
						DATA_FIELD_W'(rsp.status));
				if (rsp.rdata != want.rdata)
					report("rdata", want.rdata, rsp.rdata);
				if (rsp.slot != want.slot)
					report("slot", DATA_FIELD_W'(want.slot), DATA_FIELD_W'(rsp.slot));
			end
			rsp_hold = draw_wait(rsp_calm);
		end else if (rsp_hold > 0) begin
			rsp_hold--;
		end
		rsp_ready <= (rsp_hold == 0);
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		req_t r;
		int   used;
		int   roll;
		for (int i = 0; i < SLOTS; i++)
			stored_data[i] = '0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = (i < 8) ? KEY_FIELD_W'(i) : $urandom;

		add_step(FUNC_READ,  32'h0,        32'h0,        1, '{ST_MISSING, 32'h0, 4'd0});
		add_step(FUNC_WRITE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, '{ST_MISSING, 32'h0, 4'd0});
		add_step(FUNC_FREE,  32'h0,        32'h0,        1, '{ST_MISSING, 32'h0, 4'd0});
		add_step(FUNC_ALLOC, 32'hFFFFFFFF, 32'h0,        1, '{ST_DONE,    32'h0, 4'd0});
		add_step(FUNC_ALLOC, 32'h0,        32'hFFFFFFFF, 1, '{ST_DONE,    32'h0, 4'd1});
		add_step(FUNC_ALLOC, 32'hFFFFFFFF, 32'h0,        1, '{ST_PRESENT, 32'h0, 4'd0});
		add_step(FUNC_WRITE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, '{ST_DONE,    32'h0, 4'd0});
		add_step(FUNC_READ,  32'hFFFFFFFF, 32'h0,        1,
			'{ST_DONE, 32'hFFFFFFFF, 4'd0});
		add_step(FUNC_READ,  32'h0,        32'hFFFFFFFF, 1, '{ST_DONE,    32'h0, 4'd1});
		add_step(FUNC_FREE,  32'hFFFFFFFF, 32'h0,        1, '{ST_DONE,    32'h0, 4'd0});
		add_step(FUNC_READ,  32'hFFFFFFFF, 32'h0,        1, '{ST_MISSING, 32'h0, 4'd0});
		for (int i = 0; i < SLOTS-1; i++)
			add_step(FUNC_ALLOC, 32'h100 + i, $urandom, 0, '0);
		add_step(FUNC_ALLOC, 32'hA5A5A5A5, 32'h0,        1, '{ST_FULL,    32'h0, 4'd0});
		add_step(FUNC_FREE,  32'h0,        32'h0,        1, '{ST_DONE,    32'h0, 4'd1});
		add_step(FUNC_READ,  32'h100,      32'h0,        0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			push_item(plan[i].item, plan[i].typed, plan[i].want);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			used = count_used();
			if (used == SLOTS)
				filling = 1'b0;
			else if (used == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 199) == 0)
				filling = !filling;
			roll = $urandom_range(0, 99);
			if (roll < (filling ? 45 : 10))
				r.func = FUNC_ALLOC;
			else if (roll < (filling ? 65 : 30))
				r.func = FUNC_READ;
			else if (roll < (filling ? 90 : 55))
				r.func = FUNC_WRITE;
			else
				r.func = FUNC_FREE;
			r.key   = pick_key(r.func == FUNC_ALLOC ? 20 : 80);
			r.wdata = pick_data();
			push_item(r, 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ----- id_keyed_slot_table.f -----
rtl/idst_pkg.sv
rtl/idst_key_store.sv
rtl/idst_data_store.sv
rtl/id_keyed_slot_table.sv
rtl/idst_checker.sv
dv/id_keyed_slot_table_tb.sv
